/* hw/rtl/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/kpie_pkg.sv */
// Shared types, character codes and helpers for the key path index extractor.
package kpie_pkg;

  // Width of section lengths carried in commands (sections hold at most 63 bytes)
  localparam int LEN_W = 6;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_X     = 8'h58;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_F  = 8'h66;

  typedef enum logic [1:0] {
    CMD_SECTION,
    CMD_FINAL,
    CMD_FAIL
  } cmd_kind_t;

  // One unit of back-end work: emit a buffered section and its closing item, or for a failure only the closing item
  typedef struct packed {
    cmd_kind_t         kind;
    logic              bank;
    logic [LEN_W-1:0]  length;
    logic [LEN_W-1:0]  prefix;
    logic              index_valid;
    logic [3:0]        index_slot;
    logic [15:0]       index_value;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  pattern_char;
    logic        index_valid;
    logic [3:0]  index_slot;
    logic [15:0] index_value;
    logic        key_done;
    logic        key_ok;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_CHAR,
    BK_TAIL
  } back_state_t;

  // Decode a lowercase hex digit: {is_digit, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] res;
    res = 5'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      res = {1'b1, 4'(c - CHAR_0)};
    end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
      res = {1'b1, 4'(c - CHAR_LC_A + 8'd10)};
    end
    return res;
  endfunction

endpackage

/* hw/rtl/kpie_in_if.sv */
// Input channel: one key character per transaction.
interface kpie_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

/* hw/rtl/kpie_out_if.sv */
// Result channel: one pattern character or status item per transaction.
interface kpie_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pattern_char;
  logic        index_valid;
  logic [3:0]  index_slot;
  logic [15:0] index_value;
  logic        key_done;
  logic        key_ok;
  logic        last;

  modport source (output valid, output pattern_char, output index_valid,
                  output index_slot, output index_value, output key_done,
                  output key_ok, output last, input ready);
  modport sink   (input valid, input pattern_char, input index_valid,
                  input index_slot, input index_value, input key_done,
                  input key_ok, input last, output ready);
endinterface

/* hw/rtl/key_path_index_extractor.sv */
// Key path index extractor: an ordinary key character is accepted and stored in
// a two-bank section buffer; a '/' or the terminator queues a command, and the
// back end then starts from its idle state and replays the section from the buffer
// RAM, each character by a registered read followed by an output load, and then
// emits the closing '/' or key-done item. The two-entry command queue and the two
// buffer banks let one section fill while the previous one drains; the input stalls
// only when two sections are waiting to be emitted. No clearing pass is needed
// after reset.
module key_path_index_extractor import kpie_pkg::*; #(
  parameter int SECTION_MAX      = 63,
  parameter int INDEX_DIGITS_MAX = 4,
  parameter int INDICES_MAX      = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  kpie_in_if.sink   in_ch,
  kpie_out_if.source out_ch
);

  localparam int IDX_W = $clog2(SECTION_MAX + 1);

  cmd_t           push_cmd, head_cmd;
  logic           push, pop, fifo_full, fifo_empty;
  logic           ram_we, ram_re;
  logic [IDX_W:0] ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;
  out_item_t      out_item;

  kpie_front #(
    .SECTION_MAX      (SECTION_MAX),
    .INDEX_DIGITS_MAX (INDEX_DIGITS_MAX),
    .INDICES_MAX      (INDICES_MAX),
    .IDX_W            (IDX_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_char   (in_ch.char_code),
    .in_ready  (in_ch.ready),
    .push      (push),
    .push_cmd  (push_cmd),
    .fifo_full (fifo_full),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  kpie_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .head_cmd (head_cmd),
    .empty    (fifo_empty)
  );

  kpie_ram #(
    .WIDTH (8),
    .DEPTH (2 ** (IDX_W + 1))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kpie_back #(
    .SECTION_MAX (SECTION_MAX),
    .IDX_W       (IDX_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_cmd   (head_cmd),
    .fifo_empty (fifo_empty),
    .pop        (pop),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_item   (out_item),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready)
  );

  // Drive the result channel payload
  assign out_ch.pattern_char = out_item.pattern_char;
  assign out_ch.index_valid  = out_item.index_valid;
  assign out_ch.index_slot   = out_item.index_slot;
  assign out_ch.index_value  = out_item.index_value;
  assign out_ch.key_done     = out_item.key_done;
  assign out_ch.key_ok       = out_item.key_ok;
  assign out_ch.last         = out_item.last;

endmodule

/* hw/rtl/kpie_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module kpie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/kpie_cmd_fifo.sv */
// Two-entry command queue between the front and back ends.
module kpie_cmd_fifo import kpie_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head_cmd,
  output logic empty
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* hw/rtl/kpie_front.sv */
// Front end: accepts key characters, buffers sections and queues emit commands.
module kpie_front import kpie_pkg::*; #(
  parameter int SECTION_MAX      = 63,
  parameter int INDEX_DIGITS_MAX = 4,
  parameter int INDICES_MAX      = 16,
  parameter int IDX_W            = $clog2(SECTION_MAX + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [7:0]       in_char,
  output logic             in_ready,
  output logic             push,
  output cmd_t             push_cmd,
  input  logic             fifo_full,
  output logic             ram_we,
  output logic [IDX_W:0]   ram_waddr,
  output logic [7:0]       ram_wdata
);

  localparam int RUN_W = $clog2(INDEX_DIGITS_MAX + 2);
  localparam int CNT_W = $clog2(INDICES_MAX + 1);

  logic [IDX_W-1:0] sec_len_r, sec_len_nxt;
  logic [RUN_W-1:0] run_len_r, run_len_nxt;
  logic [15:0]      run_val_r, run_val_nxt;
  logic [CNT_W-1:0] idx_cnt_r, idx_cnt_nxt;
  logic             failed_r, failed_nxt;
  logic             bank_r, bank_nxt;

  logic             accept;
  logic [4:0]       hex;
  logic             run_too_long;
  logic             has_index;
  logic             too_many;
  logic             sec_full;

  assign in_ready = !fifo_full;
  assign accept   = in_valid && in_ready;
  assign hex      = hex_digit(in_char);

  assign run_too_long = run_len_r > RUN_W'(INDEX_DIGITS_MAX);
  assign has_index    = (run_len_r != '0) && (8'(run_len_r) != 8'(sec_len_r));
  assign too_many     = idx_cnt_r >= CNT_W'(INDICES_MAX);
  assign sec_full     = sec_len_r >= IDX_W'(SECTION_MAX);

  assign ram_waddr = {bank_r, sec_len_r};
  assign ram_wdata = in_char;

  // Classify the transaction and update the per-key state
  always_comb begin
    sec_len_nxt = sec_len_r;
    run_len_nxt = run_len_r;
    run_val_nxt = run_val_r;
    idx_cnt_nxt = idx_cnt_r;
    failed_nxt  = failed_r;
    bank_nxt    = bank_r;
    push        = 1'b0;
    ram_we      = 1'b0;

    push_cmd             = '0;
    push_cmd.kind        = CMD_FAIL;
    push_cmd.bank        = bank_r;
    push_cmd.length      = LEN_W'(sec_len_r);
    push_cmd.prefix      = LEN_W'(sec_len_r);

    if (accept) begin
      priority if (failed_r) begin
        // Drop everything up to the terminator
        if (in_char == CHAR_NUL) begin
          sec_len_nxt = '0;
          run_len_nxt = '0;
          run_val_nxt = '0;
          idx_cnt_nxt = '0;
          failed_nxt  = 1'b0;
        end
      end else if (in_char == CHAR_NUL) begin
        push          = 1'b1;
        push_cmd.kind = CMD_FINAL;
        bank_nxt      = !bank_r;
        sec_len_nxt   = '0;
        run_len_nxt   = '0;
        run_val_nxt   = '0;
        idx_cnt_nxt   = '0;
      end else if (in_char == CHAR_SLASH) begin
        push        = 1'b1;
        bank_nxt    = !bank_r;
        sec_len_nxt = '0;
        run_len_nxt = '0;
        run_val_nxt = '0;
        if (run_too_long || (has_index && too_many)) begin
          push_cmd.kind = CMD_FAIL;
          failed_nxt    = 1'b1;
        end else begin
          push_cmd.kind = CMD_SECTION;
          if (has_index) begin
            push_cmd.prefix      = LEN_W'(sec_len_r) - LEN_W'(run_len_r);
            push_cmd.index_valid = 1'b1;
            push_cmd.index_slot  = 4'(idx_cnt_r);
            push_cmd.index_value = run_val_r;
            idx_cnt_nxt          = idx_cnt_r + CNT_W'(1);
          end
        end
      end else if (sec_full) begin
        // Section overflow ends the key
        push          = 1'b1;
        push_cmd.kind = CMD_FAIL;
        bank_nxt      = !bank_r;
        failed_nxt    = 1'b1;
        sec_len_nxt   = '0;
        run_len_nxt   = '0;
        run_val_nxt   = '0;
      end else begin
        // Buffer the character and track the trailing hex run
        ram_we      = 1'b1;
        sec_len_nxt = sec_len_r + IDX_W'(1);
        if (hex[4]) begin
          if (run_len_r <= RUN_W'(INDEX_DIGITS_MAX)) begin
            run_len_nxt = run_len_r + RUN_W'(1);
          end
          run_val_nxt = {run_val_r[11:0], hex[3:0]};
        end else begin
          run_len_nxt = '0;
          run_val_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_len_r <= '0;
      run_len_r <= '0;
      run_val_r <= '0;
      idx_cnt_r <= '0;
      failed_r  <= 1'b0;
      bank_r    <= 1'b0;
    end else begin
      sec_len_r <= sec_len_nxt;
      run_len_r <= run_len_nxt;
      run_val_r <= run_val_nxt;
      idx_cnt_r <= idx_cnt_nxt;
      failed_r  <= failed_nxt;
      bank_r    <= bank_nxt;
    end
  end

endmodule

/* hw/rtl/kpie_back.sv */
// Back end: replays a buffered section from RAM and emits its closing item.
module kpie_back import kpie_pkg::*; #(
  parameter int SECTION_MAX = 63,
  parameter int IDX_W       = $clog2(SECTION_MAX + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cmd_t           head_cmd,
  input  logic           fifo_empty,
  output logic           pop,
  output logic           ram_re,
  output logic [IDX_W:0] ram_raddr,
  input  logic [7:0]     ram_rdata,
  output out_item_t      out_item,
  output logic           out_valid,
  input  logic           out_ready
);

  back_state_t      state_r, state_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        item_r, item_nxt;
  logic             slot_free;
  logic             last_char;

  assign slot_free = !out_valid_r || out_ready;
  assign last_char = (pos_r + LEN_W'(1)) == head_cmd.length;
  assign ram_raddr = {head_cmd.bank, pos_r[IDX_W-1:0]};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!fifo_empty) begin
          if (head_cmd.kind == CMD_FAIL || head_cmd.length == '0) begin
            state_nxt = BK_TAIL;
          end else begin
            state_nxt = BK_FETCH;
          end
        end
      end
      BK_FETCH: state_nxt = BK_CHAR;
      BK_CHAR: begin
        if (slot_free) begin
          state_nxt = last_char ? BK_TAIL : BK_FETCH;
        end
      end
      BK_TAIL: begin
        if (slot_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs: read strobe, output register load, queue pop
  always_comb begin
    ram_re        = 1'b0;
    pop           = 1'b0;
    pos_nxt       = pos_r;
    item_nxt      = item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      BK_IDLE: pos_nxt = '0;
      BK_FETCH: ram_re = 1'b1;
      BK_CHAR: begin
        if (slot_free) begin
          item_nxt              = '0;
          item_nxt.pattern_char = (pos_r < head_cmd.prefix) ? ram_rdata : CHAR_X;
          out_valid_nxt         = 1'b1;
          pos_nxt               = pos_r + LEN_W'(1);
        end
      end
      BK_TAIL: begin
        if (slot_free) begin
          item_nxt      = '0;
          item_nxt.last = 1'b1;
          out_valid_nxt = 1'b1;
          pop           = 1'b1;
          unique case (head_cmd.kind)
            CMD_SECTION: begin
              item_nxt.pattern_char = CHAR_SLASH;
              item_nxt.index_valid  = head_cmd.index_valid;
              item_nxt.index_slot   = head_cmd.index_slot;
              item_nxt.index_value  = head_cmd.index_value;
            end
            CMD_FINAL: begin
              item_nxt.key_done = 1'b1;
              item_nxt.key_ok   = 1'b1;
            end
            default: item_nxt.key_done = 1'b1;
          endcase
        end
      end
      default: pos_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_item  = item_r;
  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/kpie_checker.sv */
// Port-level checks for the key path index extractor, bound to the top level.
`include "assert_macros.svh"

module kpie_checker import kpie_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  pattern_char,
  input logic        index_valid,
  input logic [3:0]  index_slot,
  input logic [15:0] index_value,
  input logic        key_done,
  input logic        key_ok,
  input logic        last
);

  logic [31:0] out_payload;

  // Gather the result payload for the stability check
  assign out_payload = {pattern_char, index_valid, index_slot, index_value,
                        key_done, key_ok, last};

  // Hold a stalled result transaction
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_payload), "result changed while stalled")

  // A key-done item closes its burst and carries no character
  `ASSERT_IMP(a_done_last, clk, rst_n, out_valid && key_done, last && pattern_char == CHAR_NUL && !index_valid, "key-done item malformed")

  // An index is reported only on the closing slash
  `ASSERT_IMP(a_index_slash, clk, rst_n, out_valid && index_valid, last && pattern_char == CHAR_SLASH && !key_done, "index outside slash item")

  // Success is reported only with key_done
  `ASSERT_IMP(a_ok_done, clk, rst_n, out_valid && key_ok, key_done, "key_ok without key_done")

endmodule

bind key_path_index_extractor kpie_checker u_kpie_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .pattern_char (out_ch.pattern_char),
  .index_valid  (out_ch.index_valid),
  .index_slot   (out_ch.index_slot),
  .index_value  (out_ch.index_value),
  .key_done     (out_ch.key_done),
  .key_ok       (out_ch.key_ok),
  .last         (out_ch.last)
);
